[design/fsgc_pkg.sv]
// Shared types, constants and helpers for the flex-sensor gesture classifier.
// Used by the register block, the serial divider and the top level.
`default_nettype none

package fsgc_pkg;

	// Sample and level width, and finger count
	localparam int ADC_BITS  = 12;
	localparam int N_FINGERS = 4;
	localparam int FINGER_W  = $clog2(N_FINGERS);

	// Register file geometry on the APB side
	localparam int N_REGS    = 2 * N_FINGERS;
	localparam int REG_IDX_W = $clog2(N_REGS);
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int DATA_W    = 32;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_OPEN_INDEX  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_OPEN_MIDDLE = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_OPEN_RING   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_OPEN_PINKY  = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_FIST_INDEX  = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_FIST_MIDDLE = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_FIST_RING   = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_FIST_PINKY  = REG_IDX_W'(7);

	// Scoring constants
	localparam int SCORE_W = 7;
	localparam logic [SCORE_W-1:0]  FULL_SCALE = SCORE_W'(100);
	localparam logic [SCORE_W-1:0]  BENT_ABOVE = SCORE_W'(65);
	localparam logic [SCORE_W-1:0]  EXT_BELOW  = SCORE_W'(35);
	localparam logic [ADC_BITS-1:0] MIN_GAP    = ADC_BITS'(250);
	localparam logic [ADC_BITS-1:0] FALLBACK_THRESHOLD = ADC_BITS'(2048);

	// Divider: dividend is a position times full scale
	localparam int PROD_W    = ADC_BITS + SCORE_W;
	localparam int DIV_CNT_W = $clog2(PROD_W);

	// Gesture codes and the masks that select them
	localparam logic [2:0] GEST_NONE  = 3'd0;
	localparam logic [2:0] GEST_WATER = 3'd1;
	localparam logic [2:0] GEST_WC    = 3'd2;
	localparam logic [2:0] GEST_FOOD  = 3'd3;
	localparam logic [2:0] GEST_HELP  = 3'd4;

	localparam logic [N_FINGERS-1:0] MASK_HELP    = 4'hF;
	localparam logic [N_FINGERS-1:0] MASK_FOOD    = 4'h7;
	localparam logic [N_FINGERS-1:0] MASK_WC      = 4'h3;
	localparam logic [N_FINGERS-1:0] MASK_WATER   = 4'h1;
	localparam logic [N_FINGERS-1:0] MASK_WATER_B = 4'hE;

	typedef struct packed {
		logic [ADC_BITS-1:0] adc_pinky;
		logic [ADC_BITS-1:0] adc_ring;
		logic [ADC_BITS-1:0] adc_middle;
		logic [ADC_BITS-1:0] adc_index;
	} sample_t;

	typedef struct packed {
		logic [2:0]           gesture;
		logic [N_FINGERS-1:0] bent_bits;
		logic                 profiles_valid;
	} result_t;

	// Calibration view handed from the register block to the sequencer
	typedef struct packed {
		logic [N_FINGERS-1:0][ADC_BITS-1:0] open_lvl;
		logic [N_FINGERS-1:0][ADC_BITS-1:0] fist_lvl;
		logic                               profiles_ok;
		logic                               wr;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic [PROD_W-1:0]   dividend;
		logic [ADC_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

	// Map the bent mask to a gesture code
	function automatic logic [2:0] gesture_of(input logic [N_FINGERS-1:0] mask);
		logic [2:0] g;
		case (mask) inside
			MASK_HELP:                g = GEST_HELP;
			MASK_FOOD:                g = GEST_FOOD;
			MASK_WC:                  g = GEST_WC;
			MASK_WATER, MASK_WATER_B: g = GEST_WATER;
			default:                  g = GEST_NONE;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

[design/fsgc_regs.sv]
// APB register block holding the open and fist calibration levels.
// Depends on fsgc_pkg; flags the all-gaps-valid status for the sequencer.
`default_nettype none

module fsgc_regs
	import fsgc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [N_FINGERS-1:0][ADC_BITS-1:0] open_q;
	logic [N_FINGERS-1:0][ADC_BITS-1:0] fist_q;
	logic [REG_IDX_W-1:0]               idx;
	logic [FINGER_W-1:0]                fidx;
	logic                               wr_en;
	logic                               ok;
	logic [ADC_BITS-1:0]                gap;
	logic [ADC_BITS-1:0]                rd_val;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign fidx   = idx[FINGER_W-1:0];
	assign wr_en  = psel && penable && pwrite;

	// Write a level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			fist_q <= '0;
		end else if (wr_en) begin
			if (idx < REG_FIST_INDEX) begin
				open_q[fidx] <= pwdata[ADC_BITS-1:0];
			end else begin
				fist_q[fidx] <= pwdata[ADC_BITS-1:0];
			end
		end
	end

	// Read back
	always_comb begin
		if (idx < REG_FIST_INDEX) begin
			rd_val = open_q[fidx];
		end else begin
			rd_val = fist_q[fidx];
		end
		prdata = {{(DATA_W-ADC_BITS){1'b0}}, rd_val};
	end

	// Check every finger's calibration gap
	always_comb begin
		ok  = 1'b1;
		gap = '0;
		for (int k = 0; k < N_FINGERS; k++) begin
			gap = (open_q[k] > fist_q[k]) ? (open_q[k] - fist_q[k]) : (fist_q[k] - open_q[k]);
			if (gap < MIN_GAP) begin
				ok = 1'b0;
			end
		end
	end

	assign cfg.open_lvl    = open_q;
	assign cfg.fist_lvl    = fist_q;
	assign cfg.profiles_ok = ok;
	assign cfg.wr          = wr_en;

endmodule

`default_nettype wire

[design/fsgc_div.sv]
// Restoring serial divider, one quotient bit per cycle, shared by all fingers.
// Depends on fsgc_pkg for the request and response structs.
`default_nettype none

module fsgc_div
	import fsgc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(PROD_W - 1);

	logic [ADC_BITS-1:0]  rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [ADC_BITS-1:0]  dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ADC_BITS:0]    trial;
	logic                 fits;

	// Bring down the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Control: count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift one bit per step
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? ADC_BITS'(trial - {1'b0, dvs_q}) : trial[ADC_BITS-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[design/flex_sensor_gesture_classifier_unit.sv]
// Flex-sensor gesture classifier: one word of four samples in, one gesture word out.
// Each finger runs setup, a 19-step divide, done and apply when it divides, else setup and apply;
// the fingers share the divider in turn, and a new word is taken only after the last is emitted.
// With invalid profiles no finger divides.
// The result register holds a finished word while the next is taken.
// Reset (arst_n, asynchronous) clears levels, bent flags and all handshake state.
`default_nettype none

module flex_sensor_gesture_classifier_unit
	import fsgc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire sample_t           sample,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output result_t                result
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SETUP  = 5'b00010,
		ST_DIVIDE = 5'b00100,
		ST_APPLY  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	localparam logic [FINGER_W-1:0] LAST_FINGER = FINGER_W'(N_FINGERS - 1);

	state_t              state_q;
	cfg_t                cfg;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	sample_t             sample_q;
	logic                valid_q;
	logic [FINGER_W-1:0] finger_q;
	logic [SCORE_W-1:0]  score_q;
	logic [N_FINGERS-1:0] bent_flags_q;
	logic                result_valid_q;
	result_t             result_q;

	logic [N_FINGERS-1:0][ADC_BITS-1:0] adc_arr;
	logic [ADC_BITS-1:0] op;
	logic [ADC_BITS-1:0] fs;
	logic [ADC_BITS-1:0] adc;
	logic [ADC_BITS-1:0] pos;
	logic [ADC_BITS-1:0] range;
	logic                trivial;
	logic [SCORE_W-1:0]  triv_score;
	logic [SCORE_W-1:0]  div_score;
	logic                accept;
	logic                emit_fire;

	fsgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsgc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign emit_fire    = (state_q == ST_EMIT) && (!result_valid_q || result_ready);

	// Select the current finger's sample and levels
	assign adc_arr = {sample_q.adc_pinky, sample_q.adc_ring, sample_q.adc_middle,
		sample_q.adc_index};
	assign adc = adc_arr[finger_q];
	assign op  = cfg.open_lvl[finger_q];
	assign fs  = cfg.fist_lvl[finger_q];

	// Settle the cases that need no division, else set up position and range
	always_comb begin
		trivial    = 1'b1;
		triv_score = '0;
		pos        = '0;
		range      = '0;
		if (!valid_q) begin
			triv_score = (adc < FALLBACK_THRESHOLD) ? FULL_SCALE : '0;
		end else if (op > fs) begin
			range = op - fs;
			if (adc < op) begin
				pos     = op - adc;
				trivial = 1'b0;
			end
		end else begin
			range = fs - op;
			if (adc > op) begin
				pos     = adc - op;
				trivial = 1'b0;
			end
		end
		if (!trivial && range == '0) begin
			trivial = 1'b1;
		end
	end

	assign div_req.start    = (state_q == ST_SETUP) && !trivial;
	assign div_req.dividend = PROD_W'(pos) * PROD_W'(FULL_SCALE);
	assign div_req.divisor  = range;

	// Clamp the quotient to full scale
	assign div_score = (div_rsp.quotient > PROD_W'(FULL_SCALE)) ? FULL_SCALE :
		div_rsp.quotient[SCORE_W-1:0];

	// Capture the sample word and the profile status at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			valid_q  <= cfg.profiles_ok;
		end
	end

	// Sequencer over the four fingers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			finger_q     <= '0;
			bent_flags_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg.wr) begin
						bent_flags_q <= '0;
					end
					if (accept) begin
						finger_q <= '0;
						state_q  <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= trivial ? ST_APPLY : ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					// Set above the bent level, clear below the extended level, else hold
					if (score_q > BENT_ABOVE) begin
						bent_flags_q[finger_q] <= 1'b1;
					end else if (score_q < EXT_BELOW) begin
						bent_flags_q[finger_q] <= 1'b0;
					end
					if (finger_q == LAST_FINGER) begin
						state_q <= ST_EMIT;
					end else begin
						finger_q <= finger_q + 1'b1;
						state_q  <= ST_SETUP;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the finger score for the apply step
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP && trivial) begin
			score_q <= triv_score;
		end else if (state_q == ST_DIVIDE && div_rsp.done) begin
			score_q <= div_score;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			result_q.gesture        <= gesture_of(bent_flags_q);
			result_q.bent_bits      <= bent_flags_q;
			result_q.profiles_valid <= valid_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// No new word right after one is taken
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample_ready)
		else $error("sample accepted twice in a row");

	// Divider is never restarted while it runs
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// The emit step comes only after the last finger
	a_emit_last_finger: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (finger_q == LAST_FINGER))
		else $error("emit before all fingers scored");

	// A finished word carries a defined gesture code
	a_gesture_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.gesture <= GEST_HELP))
		else $error("gesture code out of range");
`endif

endmodule

`default_nettype wire

[dv/fsgc_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the flex-sensor gesture classifier: tracks the calibration levels
// and bent flags, predicts each result word and compares it. Depends on fsgc_pkg.

module fsgc_checker
	import fsgc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              sample_valid,
	input  logic              sample_ready,
	input  sample_t           sample,
	input  logic              result_valid,
	input  logic              result_ready,
	input  result_t           result,
	output int                errors,
	output int                pending
);

	logic [ADC_BITS-1:0]  open_lvl [N_FINGERS];
	logic [ADC_BITS-1:0]  fist_lvl [N_FINGERS];
	logic [N_FINGERS-1:0] bent;
	result_t              gesture_q [$];
	int                   err_cnt;

	// Bend score 0..100 of one finger; binary threshold when uncalibrated
	function automatic int bend_score(input logic [ADC_BITS-1:0] op, input logic [ADC_BITS-1:0] fs,
			input logic [ADC_BITS-1:0] adc, input bit calibrated);
		int span;
		int pos;
		int q;
		if (!calibrated)
			return (adc < FALLBACK_THRESHOLD) ? int'(FULL_SCALE) : 0;
		if (op > fs) begin
			span = int'(op) - int'(fs);
			if (adc >= op)
				return 0;
			pos = int'(op) - int'(adc);
		end else begin
			span = int'(fs) - int'(op);
			if (adc <= op)
				return 0;
			pos = int'(adc) - int'(op);
		end
		if (span == 0)
			return 0;
		q = pos * int'(FULL_SCALE) / span;
		return (q > int'(FULL_SCALE)) ? int'(FULL_SCALE) : q;
	endfunction

	// Advance the bent flags by one word and build the expected result
	function automatic result_t classify(input sample_t s);
		logic [ADC_BITS-1:0] adc [N_FINGERS];
		logic [ADC_BITS-1:0] gap;
		bit                  calibrated;
		int                  sc;
		result_t             r;
		adc[0] = s.adc_index;
		adc[1] = s.adc_middle;
		adc[2] = s.adc_ring;
		adc[3] = s.adc_pinky;
		calibrated = 1'b1;
		for (int k = 0; k < N_FINGERS; k++) begin
			gap = (open_lvl[k] > fist_lvl[k]) ? open_lvl[k] - fist_lvl[k] : fist_lvl[k] - open_lvl[k];
			if (gap < MIN_GAP)
				calibrated = 1'b0;
		end
		for (int k = 0; k < N_FINGERS; k++) begin
			sc = bend_score(open_lvl[k], fist_lvl[k], adc[k], calibrated);
			// hysteresis: set above the upper mark, clear below the lower one
			if (sc > int'(BENT_ABOVE))
				bent[k] = 1'b1;
			else if (sc < int'(EXT_BELOW))
				bent[k] = 1'b0;
		end
		if (bent == MASK_HELP)
			r.gesture = GEST_HELP;
		else if (bent == MASK_FOOD)
			r.gesture = GEST_FOOD;
		else if (bent == MASK_WC)
			r.gesture = GEST_WC;
		else if (bent == MASK_WATER || bent == MASK_WATER_B)
			r.gesture = GEST_WATER;
		else
			r.gesture = GEST_NONE;
		r.bent_bits      = bent;
		r.profiles_valid = calibrated;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [REG_IDX_W-1:0] idx;
		result_t              want;
		if (!arst_n) begin
			for (int k = 0; k < N_FINGERS; k++) begin
				open_lvl[k] = '0;
				fist_lvl[k] = '0;
			end
			bent = '0;
			gesture_q.delete();
			err_cnt = 0;
		end else begin
			// track level writes; any write drops all bent flags
			if (psel && penable && pwrite && pready) begin
				idx = paddr[ADDR_W-1:2];
				if (idx < REG_FIST_INDEX)
					open_lvl[FINGER_W'(idx)] = pwdata[ADC_BITS-1:0];
				else
					fist_lvl[FINGER_W'(idx - REG_FIST_INDEX)] = pwdata[ADC_BITS-1:0];
				bent = '0;
			end
			if (sample_valid && sample_ready)
				gesture_q.push_back(classify(sample));
			// compare each result word with the oldest prediction
			if (result_valid && result_ready) begin
				if (gesture_q.size() == 0) begin
					$error("result word with nothing pending: gesture %0d mask %h",
						result.gesture, result.bent_bits);
					err_cnt++;
				end else begin
					want = gesture_q.pop_front();
					if (result.gesture !== want.gesture) begin
						$error("gesture: expected %0d, got %0d", want.gesture, result.gesture);
						err_cnt++;
					end
					if (result.bent_bits !== want.bent_bits) begin
						$error("bent_bits: expected %h, got %h", want.bent_bits, result.bent_bits);
						err_cnt++;
					end
					if (result.profiles_valid !== want.profiles_valid) begin
						$error("profiles_valid: expected %0d, got %0d", want.profiles_valid,
							result.profiles_valid);
						err_cnt++;
					end
				end
			end
		end
		errors  <= err_cnt;
		pending <= gesture_q.size();
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the gesture classifier bench: clock, reset, APB level writes, sample and
// result traffic, verdict. Depends on fsgc_pkg, the unit and fsgc_checker.

module testbench
	import fsgc_pkg::*;
;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	sample_t           sample       = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;
	int                errors;
	int                pending;

	// levels currently programmed, used to aim samples into each finger's range
	logic [ADC_BITS-1:0] open_cfg [N_FINGERS];
	logic [ADC_BITS-1:0] fist_cfg [N_FINGERS];
	bit                  steady;

	flex_sensor_gesture_classifier_unit i_dut (.*);

	fsgc_checker i_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Often no gap, mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 15);
		if (r < 6)
			return 0;
		if (r < 14)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic sample_t word(input int i, input int m, input int r, input int p);
		sample_t s;
		s.adc_index  = ADC_BITS'(i);
		s.adc_middle = ADC_BITS'(m);
		s.adc_ring   = ADC_BITS'(r);
		s.adc_pinky  = ADC_BITS'(p);
		return s;
	endfunction

	// Sample at a fraction (per mille) of the way from open toward fist
	function automatic logic [ADC_BITS-1:0] aim(input int k, input int permille);
		int v;
		v = int'(open_cfg[k]) + (int'(fist_cfg[k]) - int'(open_cfg[k])) * permille / 1000;
		if (v < 0)
			v = 0;
		else if (v > (1 << ADC_BITS) - 1)
			v = (1 << ADC_BITS) - 1;
		return ADC_BITS'(v);
	endfunction

	// Mostly words aimed at a gesture mask, the rest noise and mid-band holds
	function automatic sample_t random_word();
		logic [N_FINGERS-1:0] gestures [5] = '{MASK_WATER, MASK_WC, MASK_FOOD, MASK_HELP,
			MASK_WATER_B};
		logic [N_FINGERS-1:0] target;
		logic [ADC_BITS-1:0]  v [N_FINGERS];
		int                   r;
		if ($urandom_range(0, 2) == 0)
			target = N_FINGERS'($urandom_range(0, 15));
		else
			target = gestures[$urandom_range(0, 4)];
		for (int k = 0; k < N_FINGERS; k++) begin
			r = $urandom_range(0, 9);
			case (r)
				0: v[k] = ADC_BITS'($urandom_range(0, 4095));
				1: v[k] = $urandom_range(0, 1) ? '1 : '0;
				2: v[k] = aim(k, $urandom_range(330, 670));
				default: begin
					if (target[k])
						v[k] = aim(k, $urandom_range(660, 1150));
					else
						v[k] = aim(k, int'($urandom_range(0, 490)) - 150);
				end
			endcase
		end
		return word(v[0], v[1], v[2], v[3]);
	endfunction

	// Calibration pair for one finger, either direction, gap healthy or short
	task automatic pick_levels(input bit healthy, output logic [ADC_BITS-1:0] op,
			output logic [ADC_BITS-1:0] fs);
		int lo;
		int gap;
		case ($urandom_range(0, 3))
			0: gap = healthy ? $urandom_range(250, 4095) : $urandom_range(0, 249);
			1: gap = healthy ? $urandom_range(250, 251) : $urandom_range(247, 249);
			2: gap = healthy ? 4095 : 0;
			default: gap = healthy ? $urandom_range(250, 1500) : $urandom_range(0, 249);
		endcase
		lo = $urandom_range(0, 4095 - gap);
		if ($urandom_range(0, 1)) begin
			op = ADC_BITS'(lo);
			fs = ADC_BITS'(lo + gap);
		end else begin
			op = ADC_BITS'(lo + gap);
			fs = ADC_BITS'(lo);
		end
	endtask

	// APB write with junk above the level bits; leaves the bus idle after
	task automatic write_level(input logic [REG_IDX_W-1:0] idx, input logic [ADC_BITS-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom() & ~DATA_W'((1 << ADC_BITS) - 1)) | DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_levels();
		for (int k = 0; k < N_FINGERS; k++)
			write_level(REG_IDX_W'(REG_OPEN_INDEX + k), open_cfg[k]);
		for (int k = 0; k < N_FINGERS; k++)
			write_level(REG_IDX_W'(REG_FIST_INDEX + k), fist_cfg[k]);
	endtask

	// Hold the word until taken; drop valid on a gap or after the last word
	task automatic push_word(input sample_t s, input bit last);
		int gap;
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		gap = steady ? 0 : idle_len();
		if (last || gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every predicted word has come back
	task automatic settle();
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_list(input sample_t words [$]);
		for (int i = 0; i < words.size(); i++)
			push_word(words[i], i == words.size() - 1);
		settle();
	endtask

	// Result side: ready runs of random length with stalls between
	initial begin
		int run;
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
			result_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		sample_t words [$];
		int      total;
		int      n;
		int      cnt;
		int      odd;
		bit      healthy;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// levels at reset: threshold fallback, edges around the threshold
		for (int k = 0; k < N_FINGERS; k++) begin
			open_cfg[k] = '0;
			fist_cfg[k] = '0;
		end
		steady = 1'b0;
		words = '{word(0, 0, 0, 0), word(4095, 4095, 4095, 4095),
			word(2047, 2048, 2048, 2048), word(4095, 0, 0, 0)};
		push_list(words);

		// both directions, full-scale ranges and a minimal 250 gap on the pinky
		open_cfg = '{4095, 4095, 0, 1000};
		fist_cfg = '{0, 0, 4095, 1250};
		apply_levels();
		words = '{
			word(4095, 4095, 0, 900),      // at open, pinky beyond open
			word(0, 0, 4095, 2000),        // at fist, pinky beyond fist
			word(1433, 1433, 2662, 1163),  // score 65: hold
			word(2662, 2662, 1433, 1087),  // score 34: clear
			word(1392, 1392, 2703, 1165),  // score 66: set
			word(2661, 2661, 1434, 1088),  // score 35: hold
			word(0, 0, 0, 1000),
			word(0, 0, 4095, 1000),
			word(0, 4095, 4095, 1000)};
		push_list(words);

		// a write drops the flags; then a 249 gap forces the fallback
		fist_cfg[3] = 1251;
		write_level(REG_FIST_PINKY, fist_cfg[3]);
		words = '{word(2047, 2047, 2048, 1125)};
		push_list(words);
		fist_cfg[3] = 1249;
		write_level(REG_FIST_PINKY, fist_cfg[3]);
		words = '{word(2048, 2047, 4095, 0), word(2047, 4095, 4095, 4095)};
		push_list(words);

		// random calibrations, each followed by a burst of words
		total = 0;
		while (total < 1950) begin
			healthy = ($urandom_range(0, 4) != 0);
			odd = $urandom_range(0, N_FINGERS - 1);
			for (int k = 0; k < N_FINGERS; k++)
				pick_levels(healthy || k != odd, open_cfg[k], fist_cfg[k]);
			apply_levels();
			steady = ($urandom_range(0, 4) == 0);
			n = $urandom_range(20, 120);
			for (int i = 0; i < n; i++)
				push_word(random_word(), i == n - 1);
			settle();
			total += n;
		end

		// drain, then watch a while for stray words
		cnt = 0;
		do begin
			@(posedge clk);
			cnt++;
		end while (pending != 0 && cnt < 20000);
		if (pending == 0) begin
			repeat (200) @(posedge clk);
			if (errors == 0)
				$display("PASSED: all results match");
			else
				$display("FAILED: results differ");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
